### sv/tpe_pkg.sv
package tpe_pkg;

    localparam int WORDS_PER_PAGE = 256;
    localparam int SLOT_W         = $clog2(WORDS_PER_PAGE);
    localparam int ADDR_W         = SLOT_W + 1;
    localparam int STORE_WORDS    = 2 * WORDS_PER_PAGE;
    localparam int LAST_SLOT      = WORDS_PER_PAGE - 1;

    localparam logic [31:0] WORD_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] RECV_ONES  = 32'h0000_FFFF;
    localparam logic [31:0] RECV_ZEROS = 32'hFFFF_0000;
    localparam logic [15:0] ADDR_NONE  = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_FORMAT = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        PST_ERASED,
        PST_ACTIVE,
        PST_RECEIVE,
        PST_INVALID
    } t_pst;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] byte_address;
        logic [1:0]  byte_count;
        logic [15:0] write_data;
    } t_req;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  bytes_done;
        logic        error;
        logic        compacted;
    } t_rsp;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLR,
        OP_FMT,
        OP_RD_S0,
        OP_RD_S1,
        OP_PICK,
        OP_SINIT,
        OP_SRCH,
        OP_RDRES,
        OP_WDEC,
        OP_ERA_DST,
        OP_CP_INIT,
        OP_CP_RD,
        OP_CP_GET,
        OP_CP_APP,
        OP_ERA_SRC,
        OP_CP_FIN,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_cmd_code cmd;
        logic      refused;
        logic      full;
        logic      no_page;
        logic      hit;
        logic      miss;
        logic      sweep_end;
        logic      slot_end;
        logic      i_zero;
    } t_sts;

    function automatic logic [31:0] erased_word(input logic ones);
        return ones ? WORD_ONES : ~WORD_ONES;
    endfunction

    function automatic logic [31:0] active_word(input logic ones);
        return ~erased_word(ones);
    endfunction

    function automatic t_pst page_status(input logic [31:0] w, input logic ones);
        t_pst s;
        if (w == erased_word(ones)) begin
            s = PST_ERASED;
        end else if (w == active_word(ones)) begin
            s = PST_ACTIVE;
        end else if (w == (ones ? RECV_ONES : RECV_ZEROS)) begin
            s = PST_RECEIVE;
        end else begin
            s = PST_INVALID;
        end
        return s;
    endfunction

endpackage

### sv/tpe_req_if.sv
interface tpe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] byte_address;
    logic [1:0]  byte_count;
    logic [15:0] write_data;

    modport source (output valid, output cmd, output byte_address, output byte_count,
                    output write_data, input ready);
    modport sink (input valid, input cmd, input byte_address, input byte_count,
                  input write_data, output ready);
endinterface

### sv/tpe_rsp_if.sv
interface tpe_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [1:0]  bytes_done;
    logic        error;
    logic        compacted;

    modport source (output valid, output read_data, output bytes_done, output error,
                    output compacted, input ready);
    modport sink (input valid, input read_data, input bytes_done, input error,
                  input compacted, output ready);
endinterface

### sv/tpe_ram.sv
module tpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tpe_datapath.sv
module tpe_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  tpe_pkg::t_req i_req,
    input  tpe_pkg::t_op  i_op,
    output tpe_pkg::t_sts o_sts,
    output tpe_pkg::t_rsp o_rsp
);

    localparam int SW = tpe_pkg::SLOT_W;
    localparam int AW = tpe_pkg::ADDR_W;

    logic                r_ones;
    logic                r_act;
    logic [SW-1:0]       r_last;
    logic [AW-1:0]       r_ptr;
    tpe_pkg::t_req       r_req;
    logic [31:0]         r_w0;
    logic                r_spage;
    logic [15:0]         r_skey;
    logic [SW-1:0]       r_sj;
    logic                r_pv;
    logic                r_hit;
    logic [15:0]         r_oldv;
    logic [SW-1:0]       r_i;
    logic [SW-1:0]       r_cc;
    logic [31:0]         r_rec;
    tpe_pkg::t_rsp       r_res;
    tpe_pkg::t_rsp       r_out;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [31:0]         w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [31:0]         w_rdata;

    logic [15:0]         w_even;
    logic                w_pair;
    logic [1:0]          w_done;
    logic [15:0]         w_newv;
    logic                w_match;
    tpe_pkg::t_pst       w_s0;
    tpe_pkg::t_pst       w_s1;
    logic                w_pg0;
    logic                w_pg1;
    logic [SW-1:0]       w_last_inc;
    logic [SW-1:0]       w_cc_inc;
    logic [SW-1:0]       w_slot_last;

    assign w_slot_last = SW'(tpe_pkg::LAST_SLOT);
    assign w_last_inc  = r_last + SW'(1);
    assign w_cc_inc    = r_cc + SW'(1);

    assign w_even = {r_req.byte_address[15:1], 1'b0};
    assign w_pair = r_req.byte_count[1] && !r_req.byte_address[0];
    assign w_done = w_pair ? 2'd2 : 2'd1;

    always_comb begin
        if (w_pair) begin
            w_newv = r_req.write_data;
        end else if (r_req.byte_address[0]) begin
            w_newv = {r_req.write_data[7:0], r_oldv[7:0]};
        end else begin
            w_newv = {r_oldv[15:8], r_req.write_data[7:0]};
        end
    end

    // status words: page 0 latched, page 1 on the read port
    assign w_s0  = tpe_pkg::page_status(r_w0, r_ones);
    assign w_s1  = tpe_pkg::page_status(w_rdata, r_ones);
    assign w_pg0 = (w_s0 == tpe_pkg::PST_ACTIVE) && (w_s1 != tpe_pkg::PST_INVALID);
    assign w_pg1 = (w_s1 == tpe_pkg::PST_ACTIVE) && (w_s0 != tpe_pkg::PST_INVALID);

    assign w_match = r_pv && (w_rdata[31:16] == r_skey);

    always_comb begin
        o_sts.cmd       = tpe_pkg::t_cmd_code'(r_req.cmd);
        o_sts.refused   = (r_req.byte_address == tpe_pkg::ADDR_NONE) || (r_req.byte_count == 2'd0);
        o_sts.full      = (r_last == w_slot_last);
        o_sts.no_page   = !(w_pg0 || w_pg1);
        o_sts.hit       = w_match;
        o_sts.miss      = !w_match && (r_sj == '0);
        o_sts.sweep_end = (r_ptr == AW'(tpe_pkg::STORE_WORDS - 1));
        o_sts.slot_end  = (r_ptr[SW-1:0] == w_slot_last);
        o_sts.i_zero    = (r_i == '0);
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = tpe_pkg::erased_word(r_ones);
        w_raddr = {r_spage, r_sj};
        unique case (i_op)
            tpe_pkg::OP_CLR: begin
                w_we    = 1'b1;
                w_wdata = (r_ptr == AW'(tpe_pkg::WORDS_PER_PAGE)) ?
                          ~tpe_pkg::WORD_ONES : tpe_pkg::WORD_ONES;
            end
            tpe_pkg::OP_FMT: begin
                w_we    = 1'b1;
                w_wdata = (r_ptr == AW'(tpe_pkg::WORDS_PER_PAGE)) ?
                          tpe_pkg::active_word(r_ones) : tpe_pkg::erased_word(r_ones);
            end
            tpe_pkg::OP_RD_S0: w_raddr = '0;
            tpe_pkg::OP_RD_S1: w_raddr = AW'(tpe_pkg::WORDS_PER_PAGE);
            tpe_pkg::OP_WDEC: begin
                w_we    = (w_newv != r_oldv) && (r_last != w_slot_last);
                w_waddr = {r_act, w_last_inc};
                w_wdata = {w_even, w_newv};
            end
            tpe_pkg::OP_ERA_DST: begin
                w_we    = 1'b1;
                w_waddr = {~r_act, r_ptr[SW-1:0]};
            end
            tpe_pkg::OP_CP_RD: w_raddr = {r_act, r_i};
            tpe_pkg::OP_CP_APP: begin
                w_we    = !r_hit && (r_cc != w_slot_last);
                w_waddr = {~r_act, w_cc_inc};
                w_wdata = r_rec;
            end
            tpe_pkg::OP_ERA_SRC: begin
                w_we    = 1'b1;
                w_waddr = {r_act, r_ptr[SW-1:0]};
            end
            tpe_pkg::OP_CP_FIN: begin
                w_we    = 1'b1;
                w_waddr = {~r_act, SW'(0)};
                w_wdata = tpe_pkg::active_word(r_ones);
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ones <= 1'b1;
            r_act  <= 1'b1;
            r_last <= '0;
            r_ptr  <= '0;
            r_pv   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ones <= i_cfg_wdata;
            end
            unique case (i_op)
                tpe_pkg::OP_LOAD: begin
                    r_req <= i_req;
                    r_ptr <= '0;
                    r_res <= '0;
                end
                tpe_pkg::OP_CLR: r_ptr <= r_ptr + AW'(1);
                tpe_pkg::OP_FMT: begin
                    r_ptr  <= r_ptr + AW'(1);
                    r_act  <= 1'b1;
                    r_last <= '0;
                end
                tpe_pkg::OP_RD_S1: r_w0 <= w_rdata;
                tpe_pkg::OP_PICK: begin
                    if (!(w_pg0 || w_pg1)) begin
                        r_res.error <= 1'b1;
                    end else begin
                        r_act <= !w_pg0;
                    end
                    r_ptr <= AW'(1);
                end
                tpe_pkg::OP_SINIT: begin
                    r_spage <= r_act;
                    r_skey  <= w_even;
                    r_sj    <= r_last;
                    r_pv    <= 1'b0;
                end
                tpe_pkg::OP_SRCH: begin
                    // one slot issued per cycle, compared in the next cycle
                    if (r_sj != '0) begin
                        r_sj <= r_sj - SW'(1);
                        r_pv <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    r_hit  <= w_match;
                    r_oldv <= w_match ? w_rdata[15:0] : 16'h0000;
                end
                tpe_pkg::OP_RDRES: begin
                    if (w_pair) begin
                        r_res.read_data <= r_oldv;
                    end else if (r_req.byte_address[0]) begin
                        r_res.read_data <= {8'h00, r_oldv[15:8]};
                    end else begin
                        r_res.read_data <= {8'h00, r_oldv[7:0]};
                    end
                    r_res.bytes_done <= w_done;
                end
                tpe_pkg::OP_WDEC: begin
                    if ((w_newv != r_oldv) && (r_last == w_slot_last)) begin
                        r_res.error <= 1'b1;
                    end else begin
                        r_res.bytes_done <= w_done;
                        if (w_newv != r_oldv) begin
                            r_last <= w_last_inc;
                        end
                    end
                end
                tpe_pkg::OP_ERA_DST: r_ptr <= r_ptr + AW'(1);
                tpe_pkg::OP_CP_INIT: begin
                    r_i  <= r_last;
                    r_cc <= '0;
                end
                tpe_pkg::OP_CP_RD: r_ptr <= '0;
                tpe_pkg::OP_CP_GET: begin
                    r_rec   <= w_rdata;
                    r_spage <= ~r_act;
                    r_skey  <= w_rdata[31:16];
                    r_sj    <= r_cc;
                    r_pv    <= 1'b0;
                end
                tpe_pkg::OP_CP_APP: begin
                    if (!r_hit && (r_cc != w_slot_last)) begin
                        r_cc <= w_cc_inc;
                    end
                    r_i <= r_i - SW'(1);
                end
                tpe_pkg::OP_ERA_SRC: r_ptr <= r_ptr + AW'(1);
                tpe_pkg::OP_CP_FIN: begin
                    r_act           <= ~r_act;
                    r_last          <= r_cc;
                    r_res.compacted <= 1'b1;
                end
                tpe_pkg::OP_PUSH: r_out <= r_res;
                default: r_ptr <= r_ptr;
            endcase
        end
    end

    tpe_ram #(
        .WIDTH (32),
        .DEPTH (tpe_pkg::STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_rsp = r_out;

endmodule

### sv/tpe_ctrl.sv
module tpe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  logic          i_rsp_ready,
    output logic          o_rsp_valid,
    input  tpe_pkg::t_sts i_sts,
    output tpe_pkg::t_op  o_op
);

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DISP,
        S_FMT,
        S_RS0,
        S_RS1,
        S_PICK,
        S_SINIT,
        S_SRCH,
        S_RDRES,
        S_WDEC,
        S_CPERA,
        S_CPI,
        S_CPRD,
        S_CPGET,
        S_CPSRCH,
        S_CPAPP,
        S_CPERS,
        S_CPFIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_rsp_ready;
        o_op    = tpe_pkg::OP_NONE;
        unique case (r_state)
            S_CLR: begin
                o_op = tpe_pkg::OP_CLR;
                if (i_sts.sweep_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_op    = tpe_pkg::OP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.cmd)
                    tpe_pkg::CMD_FORMAT: n_state = S_FMT;
                    tpe_pkg::CMD_NOP:    n_state = S_DONE;
                    tpe_pkg::CMD_READ,
                    tpe_pkg::CMD_WRITE:  n_state = S_RS0;
                endcase
            end
            S_FMT: begin
                o_op = tpe_pkg::OP_FMT;
                if (i_sts.sweep_end) n_state = S_DONE;
            end
            S_RS0: begin
                o_op    = tpe_pkg::OP_RD_S0;
                n_state = S_RS1;
            end
            S_RS1: begin
                o_op    = tpe_pkg::OP_RD_S1;
                n_state = S_PICK;
            end
            S_PICK: begin
                o_op = tpe_pkg::OP_PICK;
                priority if (i_sts.no_page || i_sts.refused) begin
                    n_state = S_DONE;
                end else if (i_sts.cmd == tpe_pkg::CMD_READ) begin
                    n_state = S_SINIT;
                end else if (i_sts.full) begin
                    n_state = S_CPERA;
                end else begin
                    n_state = S_SINIT;
                end
            end
            S_SINIT: begin
                o_op    = tpe_pkg::OP_SINIT;
                n_state = S_SRCH;
            end
            S_SRCH: begin
                o_op = tpe_pkg::OP_SRCH;
                if (i_sts.hit || i_sts.miss) begin
                    n_state = (i_sts.cmd == tpe_pkg::CMD_READ) ? S_RDRES : S_WDEC;
                end
            end
            S_RDRES: begin
                o_op    = tpe_pkg::OP_RDRES;
                n_state = S_DONE;
            end
            S_WDEC: begin
                o_op    = tpe_pkg::OP_WDEC;
                n_state = S_DONE;
            end
            // page transfer: clear destination, copy newest records, clear source
            S_CPERA: begin
                o_op = tpe_pkg::OP_ERA_DST;
                if (i_sts.slot_end) n_state = S_CPI;
            end
            S_CPI: begin
                o_op    = tpe_pkg::OP_CP_INIT;
                n_state = S_CPRD;
            end
            S_CPRD: begin
                o_op    = tpe_pkg::OP_CP_RD;
                n_state = i_sts.i_zero ? S_CPERS : S_CPGET;
            end
            S_CPGET: begin
                o_op    = tpe_pkg::OP_CP_GET;
                n_state = S_CPSRCH;
            end
            S_CPSRCH: begin
                o_op = tpe_pkg::OP_SRCH;
                if (i_sts.hit || i_sts.miss) n_state = S_CPAPP;
            end
            S_CPAPP: begin
                o_op    = tpe_pkg::OP_CP_APP;
                n_state = S_CPRD;
            end
            S_CPERS: begin
                o_op = tpe_pkg::OP_ERA_SRC;
                if (i_sts.slot_end) n_state = S_CPFIN;
            end
            S_CPFIN: begin
                o_op    = tpe_pkg::OP_CP_FIN;
                n_state = S_SINIT;
            end
            S_DONE: begin
                if (!r_valid || i_rsp_ready) begin
                    o_op    = tpe_pkg::OP_PUSH;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_valid;

endmodule

### sv/two_page_eeprom_emulation.sv
// EEPROM emulation over two flash pages of 32-bit words held in one 512-word RAM.
// i_req carries one command word (read, write, format, no-op); o_rsp returns
// exactly one result word per command. i_cfg_we/i_cfg_wdata set the erased
// polarity; write it only while no command is in flight.
// After reset a clearing pass over all 512 words rebuilds the formatted store
// (page 1 active, no records); i_req.ready stays low during it.
// Work per command, with n the newest used record slot:
//   read or write:  slots searched from n downwards, one record slot per cycle
//   format:         one RAM word written per cycle
//   write on a full page adds a page transfer: clear the destination, copy each
//   source record from the newest down unless the destination already holds its
//   address, then clear the source and mark the destination page active
// The single RAM port pair sets these rates. One command is worked at a
// time; a new command is accepted while the previous result still waits in the
// output register. If the receiver stalls, the result holds and the next command
// waits before its result is loaded.
module two_page_eeprom_emulation (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpe_req_if.sink   i_req,
    tpe_rsp_if.source o_rsp,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    tpe_pkg::t_req w_req;
    tpe_pkg::t_rsp w_rsp;
    tpe_pkg::t_sts w_sts;
    tpe_pkg::t_op  w_op;
    logic          w_req_ready;
    logic          w_rsp_valid;

    assign w_req.cmd          = i_req.cmd;
    assign w_req.byte_address = i_req.byte_address;
    assign w_req.byte_count   = i_req.byte_count;
    assign w_req.write_data   = i_req.write_data;

    tpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (w_rsp_valid),
        .i_sts       (w_sts),
        .o_op        (w_op)
    );

    tpe_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (w_req),
        .i_op        (w_op),
        .o_sts       (w_sts),
        .o_rsp       (w_rsp)
    );

    assign i_req.ready      = w_req_ready;
    assign o_rsp.valid      = w_rsp_valid;
    assign o_rsp.read_data  = w_rsp.read_data;
    assign o_rsp.bytes_done = w_rsp.bytes_done;
    assign o_rsp.error      = w_rsp.error;
    assign o_rsp.compacted  = w_rsp.compacted;

    // the clearing pass keeps commands out right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("command accepted during clearing pass");

    // a result is never loaded in the cycle right after a command is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (w_op != tpe_pkg::OP_PUSH))
        else $error("result loaded before command was decoded");

    // a failed access moves no bytes
    a_error_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.error) |-> (o_rsp.bytes_done == 2'd0))
        else $error("error result reports transferred bytes");

endmodule

### tb/tpe_scoreboard.sv
`timescale 1ns / 1ps

module tpe_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    tpe_req_if   req,
    tpe_rsp_if   rsp,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    output int   o_fail_count,
    output int   o_pending
);

    logic [31:0]   flash_mem [tpe_pkg::STORE_WORDS];
    logic          cur_page;
    int            top_slot;
    logic          ones;
    tpe_pkg::t_rsp expected_q[$];
    int            fails;

    function automatic logic [31:0] blank_word();
        return ones ? 32'hFFFF_FFFF : 32'h0000_0000;
    endfunction

    function automatic tpe_pkg::t_pst page_state(input int p);
        logic [31:0] w;
        w = flash_mem[p * tpe_pkg::WORDS_PER_PAGE];
        if (w == blank_word()) return tpe_pkg::PST_ERASED;
        if (w == ~blank_word()) return tpe_pkg::PST_ACTIVE;
        if (w == (ones ? tpe_pkg::RECV_ONES : tpe_pkg::RECV_ZEROS)) return tpe_pkg::PST_RECEIVE;
        return tpe_pkg::PST_INVALID;
    endfunction

    function automatic void wipe_page(input int p);
        for (int i = 0; i < tpe_pkg::WORDS_PER_PAGE; i++)
            flash_mem[p * tpe_pkg::WORDS_PER_PAGE + i] = blank_word();
    endfunction

    function automatic int newest_slot(input int p, input logic [15:0] a, input int lim);
        if (lim > tpe_pkg::LAST_SLOT) lim = tpe_pkg::LAST_SLOT;
        for (int i = lim; i > 0; i--)
            if (flash_mem[p * tpe_pkg::WORDS_PER_PAGE + i][31:16] == a) return i;
        return 0;
    endfunction

    function automatic void format_store();
        wipe_page(0);
        wipe_page(1);
        flash_mem[tpe_pkg::WORDS_PER_PAGE] = ~blank_word();
        cur_page = 1'b1;
        top_slot = 0;
    endfunction

    function automatic void transfer_page(input int src);
        int          dst;
        int          cnt;
        logic [31:0] rec;
        dst = src ^ 1;
        cnt = 0;
        wipe_page(dst);
        flash_mem[dst * tpe_pkg::WORDS_PER_PAGE] = ones ? tpe_pkg::RECV_ONES : tpe_pkg::RECV_ZEROS;
        for (int i = (top_slot > tpe_pkg::LAST_SLOT ? tpe_pkg::LAST_SLOT : top_slot);
             i > 0; i--) begin
            rec = flash_mem[src * tpe_pkg::WORDS_PER_PAGE + i];
            if (cnt < tpe_pkg::LAST_SLOT && newest_slot(dst, rec[31:16], cnt) == 0) begin
                cnt++;
                flash_mem[dst * tpe_pkg::WORDS_PER_PAGE + cnt] = rec;
            end
        end
        wipe_page(src);
        flash_mem[dst * tpe_pkg::WORDS_PER_PAGE] = ~blank_word();
        cur_page = dst[0];
        top_slot = cnt;
    endfunction

    function automatic tpe_pkg::t_rsp eeprom_access(input tpe_pkg::t_req r);
        tpe_pkg::t_rsp o;
        tpe_pkg::t_pst s0;
        tpe_pkg::t_pst s1;
        int            pg;
        int            slot;
        logic          pair;
        logic [15:0]   even;
        logic [15:0]   oldv;
        logic [15:0]   newv;
        o = '0;
        if (r.cmd == tpe_pkg::CMD_FORMAT) begin
            format_store();
            return o;
        end
        if (r.cmd == tpe_pkg::CMD_NOP) return o;
        s0 = page_state(0);
        s1 = page_state(1);
        if (s0 == tpe_pkg::PST_ACTIVE && s1 != tpe_pkg::PST_INVALID) pg = 0;
        else if (s1 == tpe_pkg::PST_ACTIVE && s0 != tpe_pkg::PST_INVALID) pg = 1;
        else begin
            o.error = 1'b1;
            return o;
        end
        cur_page = pg[0];
        if (r.byte_address == tpe_pkg::ADDR_NONE || r.byte_count == 2'd0) return o;
        pair = r.byte_count >= 2'd2 && !r.byte_address[0];
        even = {r.byte_address[15:1], 1'b0};
        if (r.cmd == tpe_pkg::CMD_READ) begin
            slot = newest_slot(pg, even, top_slot);
            oldv = slot != 0 ? flash_mem[pg * tpe_pkg::WORDS_PER_PAGE + slot][15:0] : 16'h0;
            if (pair) o.read_data = oldv;
            else o.read_data = r.byte_address[0] ? {8'h0, oldv[15:8]} : {8'h0, oldv[7:0]};
            o.bytes_done = pair ? 2'd2 : 2'd1;
            return o;
        end
        if (top_slot >= tpe_pkg::LAST_SLOT) begin
            transfer_page(pg);
            pg = cur_page;
            o.compacted = 1'b1;
        end
        slot = newest_slot(pg, even, top_slot);
        oldv = slot != 0 ? flash_mem[pg * tpe_pkg::WORDS_PER_PAGE + slot][15:0] : 16'h0;
        if (pair) newv = r.write_data;
        else if (r.byte_address[0]) newv = {r.write_data[7:0], oldv[7:0]};
        else newv = {oldv[15:8], r.write_data[7:0]};
        if (newv != oldv) begin
            if (top_slot >= tpe_pkg::LAST_SLOT) begin
                o.error = 1'b1;
                return o;
            end
            top_slot++;
            flash_mem[pg * tpe_pkg::WORDS_PER_PAGE + top_slot] = {even, newv};
        end
        o.bytes_done = pair ? 2'd2 : 2'd1;
        return o;
    endfunction

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    always @(posedge i_clk) begin
        tpe_pkg::t_req r;
        tpe_pkg::t_rsp got;
        tpe_pkg::t_rsp exp_w;
        if (!i_rst_n) begin
            ones = 1'b1;
            format_store();
            expected_q.delete();
        end else begin
            if (i_cfg_we) ones = i_cfg_wdata;
            if (req.valid && req.ready) begin
                r.cmd          = req.cmd;
                r.byte_address = req.byte_address;
                r.byte_count   = req.byte_count;
                r.write_data   = req.write_data;
                expected_q.push_back(eeprom_access(r));
            end
            if (rsp.valid && rsp.ready) begin
                got.read_data  = rsp.read_data;
                got.bytes_done = rsp.bytes_done;
                got.error      = rsp.error;
                got.compacted  = rsp.compacted;
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected response word %h", got);
                end else begin
                    exp_w = expected_q.pop_front();
                    if (got.read_data !== exp_w.read_data || got.bytes_done !== exp_w.bytes_done
                        || got.error !== exp_w.error || got.compacted !== exp_w.compacted) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp data %h done %0d err %b cmp %b, %s",
                                     exp_w.read_data, exp_w.bytes_done, exp_w.error,
                                     exp_w.compacted,
                                     $sformatf("got %h %0d %b %b", got.read_data,
                                               got.bytes_done, got.error, got.compacted));
                    end
                end
            end
        end
    end

    initial fails = 0;

endmodule

### tb/tb_two_page_eeprom_emulation.sv
`timescale 1ns / 1ps

module tb_two_page_eeprom_emulation;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b1;
    logic gaps_on = 1'b1;
    int   fail_count;
    int   pending;
    logic [15:0] addr_pool [8];

    tpe_req_if req ();
    tpe_rsp_if rsp ();

    two_page_eeprom_emulation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_rsp       (rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    tpe_scoreboard chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .rsp          (rsp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        req.valid = 1'b0;
        req.cmd = tpe_pkg::CMD_READ;
        req.byte_address = '0;
        req.byte_count = 2'd1;
        req.write_data = '0;
        rsp.ready = 1'b0;
    end

    // receiver stalls in short bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(posedge i_clk);
        end else begin
            rsp.ready <= 1'b1;
        end
    end

    task automatic send_word(input tpe_pkg::t_cmd_code c, input logic [15:0] a,
                             input logic [1:0] n, input logic [15:0] d);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req.valid        <= 1'b1;
        req.cmd          <= c;
        req.byte_address <= a;
        req.byte_count   <= n;
        req.write_data   <= d;
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic quiesce();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_polarity(input logic v);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_traffic(input int count);
        int          k;
        logic [15:0] a;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 60) == 0)
                addr_pool[$urandom_range(0, 7)] = 16'($urandom_range(0, 65534));
            a = addr_pool[$urandom_range(0, 7)] ^ 16'($urandom_range(0, 1));
            if (a == tpe_pkg::ADDR_NONE) a = 16'hFFFE;
            k = $urandom_range(0, 99);
            if (k < 47)
                send_word(tpe_pkg::CMD_WRITE, a, 2'($urandom_range(1, 2)), 16'($urandom));
            else if (k < 94)
                send_word(tpe_pkg::CMD_READ, a, 2'($urandom_range(1, 2)), 16'($urandom));
            else if (k < 95)
                send_word(tpe_pkg::CMD_FORMAT, a, 2'd1, 16'($urandom));
            else if (k < 96)
                send_word(tpe_pkg::CMD_NOP, 16'($urandom), 2'($urandom), 16'($urandom));
            else if (k < 97)
                send_word(tpe_pkg::CMD_WRITE, tpe_pkg::ADDR_NONE, 2'($urandom), 16'($urandom));
            else
                send_word(tpe_pkg::t_cmd_code'($urandom_range(0, 1)), 16'($urandom),
                          2'($urandom_range(0, 3)), 16'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) addr_pool[i] = 16'($urandom_range(0, 65534));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_word(tpe_pkg::CMD_READ, 16'h0000, 2'd2, 16'h0);
        send_word(tpe_pkg::CMD_WRITE, 16'h0000, 2'd1, 16'h00A5);
        send_word(tpe_pkg::CMD_WRITE, 16'h0001, 2'd1, 16'h005A);
        send_word(tpe_pkg::CMD_READ, 16'h0000, 2'd2, 16'h0);
        send_word(tpe_pkg::CMD_WRITE, 16'h0001, 2'd2, 16'h1234);
        send_word(tpe_pkg::CMD_READ, 16'h0001, 2'd2, 16'h0);
        send_word(tpe_pkg::CMD_WRITE, 16'hFFFE, 2'd2, 16'hFFFF);
        send_word(tpe_pkg::CMD_WRITE, 16'hFFFE, 2'd2, 16'hFFFF);
        send_word(tpe_pkg::CMD_READ, 16'hFFFE, 2'd3, 16'h0);
        send_word(tpe_pkg::CMD_WRITE, tpe_pkg::ADDR_NONE, 2'd2, 16'h1111);
        send_word(tpe_pkg::CMD_READ, tpe_pkg::ADDR_NONE, 2'd1, 16'h0);
        send_word(tpe_pkg::CMD_WRITE, 16'h0010, 2'd0, 16'h2222);
        send_word(tpe_pkg::CMD_WRITE, 16'h0010, 2'd3, 16'h0000);
        send_word(tpe_pkg::CMD_NOP, 16'h5555, 2'd2, 16'hAAAA);
        send_word(tpe_pkg::CMD_FORMAT, 16'h0, 2'd1, 16'h0);
        send_word(tpe_pkg::CMD_READ, 16'h0000, 2'd2, 16'h0);

        // fill a page with distinct pairs, then overflow after the transfer
        for (int i = 0; i < tpe_pkg::LAST_SLOT; i++)
            send_word(tpe_pkg::CMD_WRITE, 16'(2 * i), 2'd2, 16'(i + 1));
        send_word(tpe_pkg::CMD_WRITE, 16'h4000, 2'd2, 16'h0077);
        send_word(tpe_pkg::CMD_READ, 16'h0002, 2'd2, 16'h0);
        send_word(tpe_pkg::CMD_FORMAT, 16'h0, 2'd1, 16'h0);

        random_traffic(600);
        set_polarity(1'b0);
        random_traffic(20);
        send_word(tpe_pkg::CMD_FORMAT, 16'h0, 2'd1, 16'h0);
        random_traffic(350);
        set_polarity(1'b1);
        send_word(tpe_pkg::CMD_READ, 16'h0, 2'd2, 16'h0);
        send_word(tpe_pkg::CMD_FORMAT, 16'h0, 2'd1, 16'h0);
        random_traffic(250);
        gaps_on = 1'b0;
        random_traffic(150);
        quiesce();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
